// ===== rtl/sorted_alarm_timer_queue_macros.svh =====
// Assertion macros for the alarm queue checker
`ifndef SORTED_ALARM_TIMER_QUEUE_MACROS_SVH
`define SORTED_ALARM_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SATQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SATQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/satq_pkg.sv =====
package satq_pkg;

	localparam int TIME_W = 63;
	localparam int TICK_W = 32;
	localparam int FUNC_W = 2;
	localparam int ID_W   = 4;
	localparam int IDX_EXT_W = 7;
	localparam int DIV_CNT_W = 6;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = DIV_CNT_W'(TIME_W - 1);

	localparam logic [FUNC_W-1:0] FN_ONESHOT  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PERIODIC = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CANCEL   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_TICK     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FIND,
		ST_SHIFT,
		ST_CALC,
		ST_DIV,
		ST_FIX,
		ST_INS
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic ptr_clr;
		logic ptr_inc;
		logic shift_dn;
		logic unlink_end;
		logic tick_pick;
		logic calc;
		logic div_step;
		logic div_fix;
		logic ins_shift;
		logic ins_put;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic id_ok;
		logic slot_armed;
		logic cnt_zero;
		logic cnt_full;
		logic find_end;
		logic find_hit;
		logic shift_end;
		logic tick_due;
		logic per_nz;
		logic need_div;
		logic div_last;
		logic ins_stop;
		logic out_busy;
	} status_t;

endpackage

// ===== rtl/satq_ctrl.sv =====
module satq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  satq_pkg::status_t   sts,
	output satq_pkg::cmd_t      cmd
);

	satq_pkg::state_t state_q, state_d, post_unlink;
	logic             done_req;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= satq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// where to go once a slot has left the list (ST_IDLE marks completion)
	always_comb begin
		post_unlink = satq_pkg::ST_IDLE;
		if (sts.func == satq_pkg::FN_ONESHOT || sts.func == satq_pkg::FN_PERIODIC) begin
			post_unlink = satq_pkg::ST_CALC;
		end else if (sts.func == satq_pkg::FN_TICK) begin
			post_unlink = satq_pkg::ST_CALC;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		done_req = 1'b0;
		case (state_q)
			satq_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_in  = in_valid;
				if (in_valid) begin
					state_d = satq_pkg::ST_DECODE;
				end
			end
			satq_pkg::ST_DECODE: begin
				if (sts.func == satq_pkg::FN_TICK) begin
					if (!sts.cnt_zero && sts.tick_due) begin
						cmd.tick_pick = 1'b1;
						cmd.ptr_clr   = 1'b1;
						state_d       = satq_pkg::ST_SHIFT;
					end else begin
						done_req = 1'b1;
					end
				end else if (!sts.id_ok) begin
					done_req = 1'b1;
				end else if (sts.slot_armed) begin
					cmd.ptr_clr = 1'b1;
					state_d     = satq_pkg::ST_FIND;
				end else if (sts.func == satq_pkg::FN_CANCEL) begin
					done_req = 1'b1;
				end else begin
					state_d = satq_pkg::ST_CALC;
				end
			end
			satq_pkg::ST_FIND: begin
				if (sts.find_end) begin
					cmd.unlink_end = 1'b1;
					if (post_unlink == satq_pkg::ST_IDLE) begin
						done_req = 1'b1;
					end else begin
						state_d = post_unlink;
					end
				end else if (sts.find_hit) begin
					state_d = satq_pkg::ST_SHIFT;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			satq_pkg::ST_SHIFT: begin
				cmd.shift_dn = 1'b1;
				if (sts.shift_end) begin
					cmd.unlink_end = 1'b1;
					if (post_unlink == satq_pkg::ST_IDLE) begin
						done_req = 1'b1;
					end else begin
						state_d = post_unlink;
					end
				end
			end
			satq_pkg::ST_CALC: begin
				// an expired one-shot alarm is not linked again, and none is linked into a full list
				if (sts.cnt_full || (sts.func == satq_pkg::FN_TICK && !sts.per_nz)) begin
					done_req = 1'b1;
				end else begin
					cmd.calc = 1'b1;
					state_d  = sts.need_div ? satq_pkg::ST_DIV : satq_pkg::ST_INS;
				end
			end
			satq_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = satq_pkg::ST_FIX;
				end
			end
			satq_pkg::ST_FIX: begin
				cmd.div_fix = 1'b1;
				state_d     = satq_pkg::ST_INS;
			end
			satq_pkg::ST_INS: begin
				if (sts.ins_stop) begin
					cmd.ins_put = 1'b1;
					done_req    = 1'b1;
				end else begin
					cmd.ins_shift = 1'b1;
				end
			end
			default: begin
				state_d = satq_pkg::ST_IDLE;
			end
		endcase
		// finish: hand the result to the output register once it is free
		if (done_req) begin
			if (!sts.out_busy) begin
				cmd.ld_out = 1'b1;
				state_d    = satq_pkg::ST_IDLE;
			end else begin
				cmd.ins_put   = 1'b0;
				cmd.unlink_end = 1'b0;
				cmd.shift_dn  = 1'b0;
				cmd.tick_pick = 1'b0;
				cmd.ptr_clr   = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/satq_dp.sv =====
module satq_dp #(
	parameter int ALARM_SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  satq_pkg::cmd_t                    cmd,
	output satq_pkg::status_t                 sts,
	input  logic [satq_pkg::FUNC_W-1:0]       func,
	input  logic [satq_pkg::ID_W-1:0]         alarm_id,
	input  logic [satq_pkg::TIME_W-1:0]       now_time,
	input  logic [satq_pkg::TICK_W-1:0]       delay_ticks,
	input  logic [satq_pkg::TIME_W-1:0]       start_time,
	input  logic [satq_pkg::TICK_W-1:0]       period_ticks,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              expired_valid,
	output logic [satq_pkg::ID_W-1:0]         expired_id,
	output logic                              timer_armed,
	output logic [satq_pkg::TIME_W-1:0]       timer_fire_time
);

	localparam int IDX_W = $clog2(ALARM_SLOTS);
	localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
	localparam int TW    = satq_pkg::TIME_W;
	localparam int PW    = satq_pkg::TICK_W;

	// captured item
	logic [satq_pkg::FUNC_W-1:0] func_q;
	logic [satq_pkg::IDX_EXT_W-1:0] id_ext_q;
	logic [TW-1:0]  now_q, start_q;
	logic [PW-1:0]  delay_q, period_q;
	logic [IDX_W-1:0] slot_q;

	// slot state
	logic [ALARM_SLOTS-1:0] armed_q;
	logic [PW-1:0] per_mem [ALARM_SLOTS];
	logic [TW-1:0] st_mem [ALARM_SLOTS];
	logic [PW-1:0] per_rd_q;
	logic [TW-1:0] st_rd_q;

	// ordered list
	logic [IDX_W-1:0] ord_id_q [ALARM_SLOTS];
	logic [TW-1:0]    ord_fire_q [ALARM_SLOTS];
	logic [CNT_W-1:0] cnt_q, ptr_q, ptr_nx, ptr_pv;
	logic [IDX_W-1:0] pi, pn, pp;

	// fire time work registers
	logic [TW-1:0]  fire_q, dvd_q;
	logic [PW-1:0]  rem_q, per_cur_q;
	logic [satq_pkg::DIV_CNT_W-1:0] bit_q;
	logic           exp_q;

	// output register
	logic           ov_q, oexp_q, oarm_q;
	logic [satq_pkg::ID_W-1:0] oid_q;
	logic [TW-1:0]  ofire_q;

	logic [satq_pkg::IDX_EXT_W-1:0] id_ext, slot_ext;
	logic [IDX_W-1:0] in_slot;
	logic           oneshot;
	logic [PW-1:0]  src_per;
	logic [TW-1:0]  src_st;
	logic [TW:0]    os_sum, fix_sum;
	logic [PW:0]    trial;

	assign id_ext  = satq_pkg::IDX_EXT_W'(alarm_id);
	assign in_slot = id_ext[IDX_W-1:0];
	assign slot_ext = satq_pkg::IDX_EXT_W'(slot_q);

	assign ptr_nx = ptr_q + CNT_W'(1);
	assign ptr_pv = ptr_q - CNT_W'(1);
	assign pi = ptr_q[IDX_W-1:0];
	assign pn = ptr_nx[IDX_W-1:0];
	assign pp = ptr_pv[IDX_W-1:0];

	// source of the next fire time
	assign oneshot = (func_q == satq_pkg::FN_ONESHOT);
	assign src_per = (func_q == satq_pkg::FN_TICK) ? per_rd_q : period_q;
	assign src_st  = (func_q == satq_pkg::FN_TICK) ? st_rd_q : start_q;
	assign os_sum  = (TW+1)'(now_q) + (TW+1)'(delay_q);
	// start + (q + 1) * period equals now - rem + period
	assign fix_sum = (TW+1)'(now_q) - (TW+1)'(rem_q) + (TW+1)'(per_cur_q);
	assign trial   = {rem_q, dvd_q[TW-1]};

	// status towards the controller
	always_comb begin
		sts            = '0;
		sts.func       = func_q;
		sts.id_ok      = id_ext_q < satq_pkg::IDX_EXT_W'(ALARM_SLOTS);
		sts.slot_armed = armed_q[slot_q];
		sts.cnt_zero   = (cnt_q == '0);
		sts.cnt_full   = (cnt_q == CNT_W'(ALARM_SLOTS));
		sts.find_end   = (ptr_q == cnt_q);
		sts.find_hit   = (ord_id_q[pi] == slot_q);
		sts.shift_end  = (ptr_nx >= cnt_q);
		sts.tick_due   = (now_q >= ord_fire_q[0]);
		sts.per_nz     = (per_rd_q != '0);
		sts.need_div   = !oneshot && (src_per != '0) && (src_st < now_q);
		sts.div_last   = (bit_q == '0);
		sts.ins_stop   = (ptr_q == '0) || !(ord_fire_q[pp] > fire_q);
		sts.out_busy   = ov_q && !out_ready;
	end

	// input capture and fire time arithmetic
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			func_q   <= func;
			id_ext_q <= id_ext;
			slot_q   <= in_slot;
			now_q    <= now_time;
			delay_q  <= delay_ticks;
			start_q  <= start_time;
			period_q <= period_ticks;
		end
		if (cmd.tick_pick) begin
			slot_q <= ord_id_q[0];
		end
		if (cmd.calc) begin
			per_cur_q <= src_per;
			dvd_q     <= now_q - src_st;
			rem_q     <= '0;
			bit_q     <= satq_pkg::DIV_LAST_BIT;
			if (oneshot) begin
				fire_q <= os_sum[TW] ? satq_pkg::TIME_MAX : os_sum[TW-1:0];
			end else begin
				fire_q <= src_st;
			end
		end
		// restoring division, one quotient bit a cycle, remainder kept
		if (cmd.div_step) begin
			rem_q <= (trial >= (PW+1)'(per_cur_q)) ?
				PW'(trial - (PW+1)'(per_cur_q)) : trial[PW-1:0];
			dvd_q <= {dvd_q[TW-2:0], 1'b0};
			bit_q <= bit_q - satq_pkg::DIV_CNT_W'(1);
		end
		if (cmd.div_fix) begin
			fire_q <= fix_sum[TW] ? satq_pkg::TIME_MAX : fix_sum[TW-1:0];
		end
	end

	// per-slot period and start memories
	always_ff @(posedge clk) begin
		if (cmd.calc && func_q != satq_pkg::FN_TICK) begin
			per_mem[slot_q] <= oneshot ? '0 : period_q;
			st_mem[slot_q]  <= start_q;
		end
		per_rd_q <= per_mem[slot_q];
		st_rd_q  <= st_mem[slot_q];
	end

	// ordered list entries
	always_ff @(posedge clk) begin
		if (cmd.shift_dn && ptr_nx < cnt_q) begin
			ord_id_q[pi]   <= ord_id_q[pn];
			ord_fire_q[pi] <= ord_fire_q[pn];
		end
		if (cmd.ins_shift) begin
			ord_id_q[pi]   <= ord_id_q[pp];
			ord_fire_q[pi] <= ord_fire_q[pp];
		end
		if (cmd.ins_put) begin
			ord_id_q[pi]   <= slot_q;
			ord_fire_q[pi] <= fire_q;
		end
	end

	// list control: count, pointer, armed bits, expiry flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ptr_q   <= '0;
			armed_q <= '0;
			exp_q   <= 1'b0;
		end else begin
			if (cmd.ld_in) begin
				exp_q <= 1'b0;
			end
			if (cmd.tick_pick) begin
				exp_q <= 1'b1;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end
			if (cmd.ptr_inc || (cmd.shift_dn && !cmd.unlink_end)) begin
				ptr_q <= ptr_nx;
			end
			if (cmd.unlink_end) begin
				armed_q[slot_q] <= 1'b0;
				if (cmd.shift_dn) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (cmd.calc) begin
				ptr_q <= cmd.shift_dn ? ptr_q : cnt_q;
			end
			if (cmd.div_fix) begin
				ptr_q <= cnt_q;
			end
			if (cmd.ins_shift) begin
				ptr_q <= ptr_pv;
			end
			if (cmd.ins_put) begin
				cnt_q           <= cnt_q + CNT_W'(1);
				armed_q[slot_q] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.ld_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			oexp_q <= exp_q;
			oid_q  <= exp_q ? slot_ext[satq_pkg::ID_W-1:0] : '0;
			// list after this beat; pending insert counted in
			if (cmd.ins_put) begin
				oarm_q  <= 1'b1;
				ofire_q <= (ptr_q == '0) ? fire_q : ord_fire_q[0];
			end else begin
				oarm_q  <= (cnt_q != '0) && !(cmd.unlink_end && cmd.shift_dn
					&& cnt_q == CNT_W'(1));
				ofire_q <= ((cnt_q == '0) || (cmd.unlink_end && cmd.shift_dn
					&& cnt_q == CNT_W'(1))) ? '0 :
					((cmd.unlink_end && cmd.shift_dn && ptr_q == '0) ?
					ord_fire_q[pn] : ord_fire_q[0]);
			end
		end
	end

	assign out_valid       = ov_q;
	assign expired_valid   = oexp_q;
	assign expired_id      = oid_q;
	assign timer_armed     = oarm_q;
	assign timer_fire_time = ofire_q;

endmodule

// ===== rtl/sorted_alarm_timer_queue.sv =====
// Sorted alarm timer queue.
// Input channel (in_valid/in_ready) takes one command beat: set one-shot,
// set periodic, cancel, or tick check, with its slot, times and period.
// Output channel (out_valid/out_ready) returns exactly one beat per command:
// the slot that expired on a tick, and the earliest pending fire time.
// Commands are handled one at a time. A command that neither unlinks nor
// links a slot is decoded after it is accepted, and its result beat is
// loaded into the output register from the decode step. Unlinking a slot
// finds it in the list (a tick takes the head), then shifts later entries
// down; linking computes the fire time, then moves entries up one at a time
// until the new slot sits in fire-time order. A periodic fire time that
// needs the period multiple also runs the bit-serial remainder unit.
// The finished beat sits in an output register, so the next command is taken
// while it waits; a command that would complete while that register is still
// full holds in its last step until out_ready frees it.
// Reset (arst_n low) empties the list and clears every armed bit; the slot
// memories need no clearing, as only armed slots are read.
module sorted_alarm_timer_queue #(
	parameter int ALARM_SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [satq_pkg::FUNC_W-1:0]  func,
	input  logic [satq_pkg::ID_W-1:0]    alarm_id,
	input  logic [satq_pkg::TIME_W-1:0]  now_time,
	input  logic [satq_pkg::TICK_W-1:0]  delay_ticks,
	input  logic [satq_pkg::TIME_W-1:0]  start_time,
	input  logic [satq_pkg::TICK_W-1:0]  period_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         expired_valid,
	output logic [satq_pkg::ID_W-1:0]    expired_id,
	output logic                         timer_armed,
	output logic [satq_pkg::TIME_W-1:0]  timer_fire_time
);

	satq_pkg::cmd_t    cmd;
	satq_pkg::status_t sts;

	satq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	satq_dp #(
		.ALARM_SLOTS (ALARM_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.alarm_id        (alarm_id),
		.now_time        (now_time),
		.delay_ticks     (delay_ticks),
		.start_time      (start_time),
		.period_ticks    (period_ticks),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.expired_valid   (expired_valid),
		.expired_id      (expired_id),
		.timer_armed     (timer_armed),
		.timer_fire_time (timer_fire_time)
	);

endmodule

// ===== rtl/satq_chk.sv =====
`include "sorted_alarm_timer_queue_macros.svh"

module satq_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         expired_valid,
	input logic [satq_pkg::ID_W-1:0]    expired_id,
	input logic                         timer_armed,
	input logic [satq_pkg::TIME_W-1:0]  timer_fire_time
);

	// a stalled result beat holds
	`SATQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(timer_fire_time), "result beat dropped or changed while stalled")
	// empty queue reports fire time zero
	`SATQ_ASSERT_NOW(a_empty_zero, out_valid && !timer_armed, timer_fire_time == '0, "fire time not zero on empty queue")
	// no expiry means slot zero
	`SATQ_ASSERT_NOW(a_noexp_id, out_valid && !expired_valid, expired_id == '0, "expired id set without expiry")
	// one command at a time
	`SATQ_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second command taken while busy")

endmodule

bind sorted_alarm_timer_queue satq_chk u_satq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.expired_valid   (expired_valid),
	.expired_id      (expired_id),
	.timer_armed     (timer_armed),
	.timer_fire_time (timer_fire_time)
);

// ===== tb/sorted_alarm_timer_queue_test.sv =====
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_test;

	localparam int TIME_W = satq_pkg::TIME_W;
	localparam int TICK_W = satq_pkg::TICK_W;
	localparam int FUNC_W = satq_pkg::FUNC_W;
	localparam int ID_W   = satq_pkg::ID_W;
	localparam logic [FUNC_W-1:0] FN_ONESHOT  = satq_pkg::FN_ONESHOT;
	localparam logic [FUNC_W-1:0] FN_PERIODIC = satq_pkg::FN_PERIODIC;
	localparam logic [FUNC_W-1:0] FN_CANCEL   = satq_pkg::FN_CANCEL;
	localparam logic [FUNC_W-1:0] FN_TICK     = satq_pkg::FN_TICK;

	localparam int SLOTS = 16;
	localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] now;
		logic [TICK_W-1:0] delay;
		logic [TIME_W-1:0] start;
		logic [TICK_W-1:0] period;
	} cmd_beat_t;

	typedef struct packed {
		logic              exp_v;
		logic [ID_W-1:0]   exp_id;
		logic              armed;
		logic [TIME_W-1:0] fire;
	} alarm_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [ID_W-1:0] alarm_id = '0;
	logic [TIME_W-1:0] now_time = '0;
	logic [TICK_W-1:0] delay_ticks = '0;
	logic [TIME_W-1:0] start_time = '0;
	logic [TICK_W-1:0] period_ticks = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic expired_valid;
	logic [ID_W-1:0] expired_id;
	logic timer_armed;
	logic [TIME_W-1:0] timer_fire_time;

	sorted_alarm_timer_queue #(.ALARM_SLOTS(SLOTS)) dut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic              m_armed [SLOTS] = '{default: 1'b0};
	logic [TIME_W-1:0] m_fire [SLOTS];
	logic [TICK_W-1:0] m_period [SLOTS];
	logic [TIME_W-1:0] m_start [SLOTS];
	logic [ID_W-1:0]   m_order [SLOTS];
	int                m_count = 0;

	cmd_beat_t     cmds_pending[$];
	alarm_report_t reports_due[$];
	int  errors = 0;
	int  send_idle = 15, recv_idle = 85;
	bit  hold_off = 1'b0;
	bit  stall_start = 1'b0;

	function automatic logic [TIME_W-1:0] next_periodic(logic [TIME_W-1:0] st,
			logic [TICK_W-1:0] per, logic [TIME_W-1:0] now);
		logic [63:0] k, room;
		if (per == 0 || st >= now) return st;
		k = 64'(now - st) / 64'(per) + 1;
		room = 64'(T_MAX - st);
		if (k > room / 64'(per)) return T_MAX;
		return st + TIME_W'(k * 64'(per));
	endfunction

	function automatic void drop_slot(int id);
		for (int i = 0; i < m_count; i++)
			if (m_order[i] == id) begin
				for (int j = i; j + 1 < m_count; j++) m_order[j] = m_order[j+1];
				m_count--;
				break;
			end
		m_armed[id] = 1'b0;
	endfunction

	function automatic void place_slot(int id, logic [TIME_W-1:0] t);
		int pos;
		pos = 0;
		if (m_count >= SLOTS) return;
		while (pos < m_count && m_fire[m_order[pos]] <= t) pos++;
		for (int j = m_count; j > pos; j--) m_order[j] = m_order[j-1];
		m_order[pos] = ID_W'(id);
		m_count++;
		m_fire[id] = t;
		m_armed[id] = 1'b1;
	endfunction

	function automatic alarm_report_t predict_alarm(cmd_beat_t c);
		alarm_report_t r;
		int h;
		r = '0;
		case (c.func)
			FN_ONESHOT: begin
				if (m_armed[c.id]) drop_slot(c.id);
				m_period[c.id] = '0;
				m_start[c.id] = '0;
				place_slot(c.id, (T_MAX - c.now < TIME_W'(c.delay)) ? T_MAX
					: c.now + TIME_W'(c.delay));
			end
			FN_PERIODIC: begin
				if (m_armed[c.id]) drop_slot(c.id);
				m_period[c.id] = c.period;
				m_start[c.id] = c.start;
				place_slot(c.id, next_periodic(c.start, c.period, c.now));
			end
			FN_CANCEL: if (m_armed[c.id]) drop_slot(c.id);
			FN_TICK: if (m_count > 0) begin
				h = m_order[0];
				if (c.now >= m_fire[h]) begin
					drop_slot(h);
					r.exp_v = 1'b1;
					r.exp_id = ID_W'(h);
					if (m_period[h] != 0)
						place_slot(h, next_periodic(m_start[h], m_period[h], c.now));
				end
			end
			default: ;
		endcase
		if (m_count > 0) begin
			r.armed = 1'b1;
			r.fire = m_fire[m_order[0]];
		end
		return r;
	endfunction

	function automatic bit predict_alarm_push();
		cmd_beat_t c;
		c = '{func, alarm_id, now_time, delay_ticks, start_time, period_ticks};
		reports_due.push_back(predict_alarm(c));
		return 1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: next beat from the pending queue
	always @(posedge clk) begin
		cmd_beat_t c;
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) void'(predict_alarm_push());
			if (cmds_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
				c = cmds_pending.pop_front();
				in_valid <= 1'b1;
				func <= c.func; alarm_id <= c.id; now_time <= c.now;
				delay_ticks <= c.delay; start_time <= c.start; period_ticks <= c.period;
			end else in_valid <= 1'b0;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		alarm_report_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("unexpected result beat", 64'd1, 64'd0);
				end else begin
					e = reports_due.pop_front();
					if (expired_valid !== e.exp_v) report_mismatch("expired_valid", 64'(expired_valid), 64'(e.exp_v));
					if (expired_id !== e.exp_id) report_mismatch("expired_id", 64'(expired_id), 64'(e.exp_id));
					if (timer_armed !== e.armed) report_mismatch("timer_armed", 64'(timer_armed), 64'(e.armed));
					if (timer_fire_time !== e.fire) report_mismatch("timer_fire_time", 64'(timer_fire_time), 64'(e.fire));
				end
			end
			if (hold_off) out_ready <= 1'b0;
			else out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// long receiver hold-off, counted in cycles
	initial begin
		wait (stall_start);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [TIME_W-1:0] rand_time(logic [TIME_W-1:0] base);
		case ($urandom_range(3))
			0: return TIME_W'({$urandom, $urandom});
			1: return base + TIME_W'($urandom_range(200));
			2: return T_MAX - TIME_W'($urandom_range(300));
			default: return (base > 100) ? base - TIME_W'($urandom_range(100)) : base;
		endcase
	endfunction

	task automatic add_cmd(logic [FUNC_W-1:0] f, int id, logic [TIME_W-1:0] now,
			logic [TICK_W-1:0] d, logic [TIME_W-1:0] st, logic [TICK_W-1:0] p);
		cmds_pending.push_back('{f, ID_W'(id), now, d, st, p});
	endtask

	task automatic wait_drained();
		while (cmds_pending.size() > 0 || in_valid || reports_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n);
		logic [TIME_W-1:0] clock_now;
		logic [FUNC_W-1:0] f;
		clock_now = TIME_W'({$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) clock_now = TIME_W'({$urandom, $urandom});
			clock_now = clock_now + TIME_W'($urandom_range(40));
			f = FUNC_W'($urandom_range(3));
			if ($urandom_range(3) == 0) f = FN_TICK;
			add_cmd(f, $urandom_range(15),
				($urandom_range(19) == 0) ? rand_time(clock_now) : clock_now,
				($urandom_range(4) == 0) ? $urandom : $urandom_range(60),
				rand_time(clock_now),
				($urandom_range(4) == 0) ? $urandom : $urandom_range(50));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, saturation, zero period, re-arm, idle cancel, empty tick
		add_cmd(FN_TICK, 0, T_MAX, '0, '0, '0);
		add_cmd(FN_CANCEL, 5, 0, '0, '0, '0);
		add_cmd(FN_ONESHOT, 0, T_MAX - 5, 32'hFFFF_FFFF, '0, '0);
		add_cmd(FN_ONESHOT, 15, 0, 0, '0, '0);
		add_cmd(FN_ONESHOT, 3, 100, 50, '0, '0);
		add_cmd(FN_ONESHOT, 4, 100, 50, '0, '0);
		add_cmd(FN_PERIODIC, 7, 1000, '0, 10, 32'hFFFF_FFFF);
		add_cmd(FN_PERIODIC, 8, 10, '0, T_MAX, 0);
		add_cmd(FN_PERIODIC, 9, T_MAX, '0, 1, 1);
		add_cmd(FN_PERIODIC, 10, 500, '0, T_MAX - 3, 7);
		add_cmd(FN_PERIODIC, 11, 200, '0, 50, 0);
		add_cmd(FN_ONESHOT, 3, 100, 60, '0, '0);
		add_cmd(FN_CANCEL, 4, 0, '0, '0, '0);
		add_cmd(FN_CANCEL, 4, 0, '0, '0, '0);
		add_cmd(FN_TICK, 0, 0, '0, '0, '0);
		add_cmd(FN_TICK, 0, 160, '0, '0, '0);
		add_cmd(FN_TICK, 0, 160, '0, '0, '0);
		add_cmd(FN_TICK, 0, 2000, '0, '0, '0);
		add_cmd(FN_TICK, 0, T_MAX, '0, '0, '0);
		add_cmd(FN_TICK, 0, T_MAX, '0, '0, '0);
		add_cmd(FN_PERIODIC, 2, T_MAX, 32'hFFFF_FFFF, '0, 32'h8000_0001);
		add_cmd(FN_TICK, 0, T_MAX, '0, '0, '0);
		random_phase(180);
		wait_drained();
		send_idle = 85; recv_idle = 15;
		random_phase(180);
		// long receiver hold-off fills the block
		stall_start = 1'b1;
		wait_drained();
		send_idle = 0; recv_idle = 0;
		random_phase(190);
		wait_drained();
		repeat (120) @(posedge clk);
		if (errors == 0) $display("sorted_alarm_timer_queue regression: pass");
		else $display("sorted_alarm_timer_queue regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("sorted_alarm_timer_queue regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/satq_pkg.sv
rtl/satq_ctrl.sv
rtl/satq_dp.sv
rtl/sorted_alarm_timer_queue.sv
rtl/satq_chk.sv
tb/sorted_alarm_timer_queue_test.sv
